// ===== rtl/core/cvkt_pkg.sv =====
// ----------------------------------------------------------------------------
// cvkt_pkg
// Shared widths, codes and types of the constant-velocity Kalman tracker.
// ----------------------------------------------------------------------------
package cvkt_pkg;

  localparam int STATE_DIM = 4;
  localparam int MEAS_DIM  = 2;
  localparam int COV_N     = STATE_DIM * STATE_DIM;
  localparam int IDX_W     = $clog2(STATE_DIM);
  localparam int COV_IW    = $clog2(COV_N);

  localparam int SW     = 32;   // state word, Q16.16
  localparam int CW     = 48;   // covariance word, 2^-32
  localparam int KW     = 48;   // gain word, 2^-32
  localparam int OPW    = 49;   // multiplier operand
  localparam int HALF   = 24;   // low split of an operand magnitude
  localparam int HIW    = OPW - HALF;
  localparam int PPW    = 2 * HIW;
  localparam int ACCW   = 100;  // multiply-accumulate word
  localparam int NMW    = 97;   // divider numerator magnitude
  localparam int REMW   = 98;   // divider remainder
  localparam int FRAC   = 32;   // fraction bits of the gain quotient
  localparam int QW     = KW - 1;
  localparam int POSW   = 8;    // divider step counter
  localparam int DIV_TOP = NMW + FRAC - 1;
  localparam int LTW    = 8;
  localparam int CFG_IW = 8;
  localparam int CFG_DW = 32;

  localparam logic [1:0] FUNC_PREDICT = 2'd0;
  localparam logic [1:0] FUNC_UPDATE  = 2'd1;
  localparam logic [1:0] FUNC_INIT    = 2'd2;

  localparam logic [CFG_IW-1:0] REG_PROCESS_NOISE = 8'd0;
  localparam logic [CFG_IW-1:0] REG_MEASURE_NOISE = 8'd1;
  localparam logic [CFG_IW-1:0] REG_INITIAL_COV   = 8'd2;
  localparam logic [CFG_IW-1:0] REG_LOST_LIMIT    = 8'd3;

  localparam logic [31:0]    RST_PROCESS_NOISE = 32'd429497;
  localparam logic [31:0]    RST_MEASURE_NOISE = 32'd429496730;
  localparam logic [31:0]    RST_INITIAL_COV   = 32'd429496730;
  localparam logic [LTW-1:0] RST_LOST_LIMIT    = 8'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIN,
    ST_DIV,
    ST_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    JOB_DET,
    JOB_NUM,
    JOB_CS,
    JOB_CP
  } job_t;

  typedef struct packed {
    logic       en;
    logic       clr;
    logic       sub;
    logic [1:0] part;
  } mac_ctl_t;

endpackage

// ===== rtl/core/cvkt_if.sv =====
// ----------------------------------------------------------------------------
// cvkt_if
// Valid/ready channels of the tracker: measurement, result and register write.
// ----------------------------------------------------------------------------
interface cvkt_meas_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     func;
  logic signed [cvkt_pkg::SW-1:0] meas_x;
  logic signed [cvkt_pkg::SW-1:0] meas_y;
  modport source (output valid, func, meas_x, meas_y, input ready);
  modport sink (input valid, func, meas_x, meas_y, output ready);
endinterface

interface cvkt_res_if;
  logic                           valid;
  logic                           ready;
  logic signed [cvkt_pkg::SW-1:0] pos_x;
  logic signed [cvkt_pkg::SW-1:0] pos_y;
  logic                           tracking;
  logic                           ready_res;
  modport source (output valid, pos_x, pos_y, tracking, ready_res, input ready);
  modport sink (input valid, pos_x, pos_y, tracking, ready_res, output ready);
endinterface

interface cvkt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cvkt_pkg::CFG_IW-1:0]       index;
  logic [cvkt_pkg::CFG_DW-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/constant_velocity_kalman_tracker.sv =====
// ----------------------------------------------------------------------------
// constant_velocity_kalman_tracker
// Four-state constant-velocity Kalman tracker with a shared multiply unit.
// ----------------------------------------------------------------------------
// Predict, init and unused codes go from accept straight to the output state.
// Update, once started: the 129-step divider runs once for each of the eight
// gain entries when the determinant is positive; products use the shared multiplier.
// One item at a time; the next item is taken once the result is registered.
// Synchronous reset clears the state sets, tick count and registers to defaults.
module constant_velocity_kalman_tracker (
  input  logic   clk,
  input  logic   rst,
  cvkt_meas_if.sink   meas,
  cvkt_res_if.source  res,
  cvkt_cfg_if.sink    cfg
);
  import cvkt_pkg::*;

  seq_state_t state, state_next;
  job_t       job;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic             g;
  logic             term;
  logic [1:0]       part;

  logic [31:0]    process_noise;
  logic [31:0]    measure_noise;
  logic [31:0]    initial_cov;
  logic [LTW-1:0] lost_limit;

  logic           started;
  logic [LTW-1:0] lost_ticks;
  logic           zero_pos;
  logic           ok;
  logic signed [ACCW-1:0] det;

  logic signed [SW-1:0] st_pri  [STATE_DIM];
  logic signed [SW-1:0] st_post [STATE_DIM];
  logic signed [CW-1:0] cv_pri  [COV_N];
  logic signed [CW-1:0] cv_post [COV_N];
  logic signed [KW-1:0] k0 [STATE_DIM];
  logic signed [KW-1:0] k1 [STATE_DIM];
  logic signed [SW-1:0] mx;
  logic signed [SW-1:0] my;

  logic signed [SW-1:0] pred_st  [STATE_DIM];
  logic signed [CW-1:0] pred_cov [COV_N];

  mac_ctl_t               mac_ctl;
  logic signed [OPW-1:0]  op_a;
  logic signed [OPW-1:0]  op_b;
  logic signed [ACCW-1:0] acc;
  logic                   div_start;
  logic                   div_done;
  logic signed [KW-1:0]   div_q;

  logic signed [OPW-1:0]  s00, s01, s10, s11, e0, e1;
  logic signed [ACCW-1:0] acc_r;
  logic signed [67:0]     rnd;
  logic signed [39:0]     corr;
  logic signed [51:0]     dcov;
  logic signed [SW-1:0]   new_st;
  logic signed [CW-1:0]   new_cv;
  logic                   accept;
  logic                   out_load;

  function automatic logic signed [SW-1:0] sat_st(input logic signed [40:0] v);
    if (&v[40:SW-1] || ~|v[40:SW-1]) return v[SW-1:0];
    return v[40] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
  endfunction

  function automatic logic signed [CW-1:0] sat_cv(input logic signed [52:0] v);
    if (&v[52:CW-1] || ~|v[52:CW-1]) return v[CW-1:0];
    return v[52] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  assign meas.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign accept     = meas.valid && meas.ready;
  assign out_load   = (state == ST_OUT) && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= RST_PROCESS_NOISE;
      measure_noise <= RST_MEASURE_NOISE;
      initial_cov   <= RST_INITIAL_COV;
      lost_limit    <= RST_LOST_LIMIT;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PROCESS_NOISE: process_noise <= cfg.data;
        REG_MEASURE_NOISE: measure_noise <= cfg.data;
        REG_INITIAL_COV:   initial_cov   <= cfg.data;
        REG_LOST_LIMIT:    lost_limit    <= cfg.data[LTW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [51:0] sum;
    int ii;
    int jj;
    for (int s = 0; s < STATE_DIM; s++) begin
      if (s < MEAS_DIM) begin
        pred_st[s] = sat_st(41'(st_post[s]) + 41'(st_post[(s + MEAS_DIM) % STATE_DIM]));
      end else begin
        pred_st[s] = st_post[s];
      end
    end
    for (int e = 0; e < COV_N; e++) begin
      ii  = e / STATE_DIM;
      jj  = e % STATE_DIM;
      sum = 52'(cv_post[e]);
      if (jj < MEAS_DIM) sum = sum + 52'(cv_post[(e + MEAS_DIM) % COV_N]);
      if (ii < MEAS_DIM) begin
        sum = sum + 52'(cv_post[(e + MEAS_DIM * STATE_DIM) % COV_N]);
        if (jj < MEAS_DIM) begin
          sum = sum + 52'(cv_post[(e + MEAS_DIM * STATE_DIM + MEAS_DIM) % COV_N]);
        end
      end
      if (ii == jj) sum = sum + 52'($signed({1'b0, process_noise}));
      pred_cov[e] = sat_cv(53'(sum));
    end
  end

  always_comb begin
    s00 = OPW'(cv_pri[0]) + OPW'($signed({1'b0, measure_noise}));
    s01 = OPW'(cv_pri[1]);
    s10 = OPW'(cv_pri[STATE_DIM]);
    s11 = OPW'(cv_pri[STATE_DIM + 1]) + OPW'($signed({1'b0, measure_noise}));
    e0  = OPW'(33'(mx) - 33'(st_pri[0]));
    e1  = OPW'(33'(my) - 33'(st_pri[1]));
    op_a = s00;
    op_b = s11;
    case (job)
      JOB_DET: begin
        op_a = term ? s01 : s00;
        op_b = term ? s10 : s11;
      end
      JOB_NUM: begin
        if (!g) begin
          op_a = OPW'(cv_pri[{i, 2'd0}]);
          op_b = term ? s10 : s11;
          if (term) op_a = OPW'(cv_pri[{i, 2'd1}]);
        end else begin
          op_a = OPW'(cv_pri[{i, 2'd1}]);
          op_b = term ? s01 : s00;
          if (term) op_a = OPW'(cv_pri[{i, 2'd0}]);
        end
      end
      JOB_CS: begin
        op_a = term ? OPW'(k1[i]) : OPW'(k0[i]);
        op_b = term ? e1 : e0;
      end
      JOB_CP: begin
        op_a = term ? OPW'(k1[i]) : OPW'(k0[i]);
        op_b = term ? OPW'(cv_pri[{2'd1, j}]) : OPW'(cv_pri[{2'd0, j}]);
      end
      default: ;
    endcase
    mac_ctl.en   = (state == ST_MAC);
    mac_ctl.clr  = !term && (part == 2'd0);
    mac_ctl.sub  = term && (job == JOB_DET || job == JOB_NUM);
    mac_ctl.part = part;
  end

  cvkt_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (op_a),
    .b   (op_b),
    .acc (acc)
  );

  assign div_start = (state == ST_FIN) && (job == JOB_NUM) && ok;

  cvkt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (det),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    acc_r = acc + ACCW'(64'd2147483648);
    rnd   = $signed(acc_r[ACCW-1:FRAC]);
    if (&rnd[67:39] || ~|rnd[67:39]) corr = rnd[39:0];
    else corr = rnd[67] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    if (&rnd[67:51] || ~|rnd[67:51]) dcov = rnd[51:0];
    else dcov = rnd[67] ? {1'b1, 51'd0} : {1'b0, {51{1'b1}}};
    new_st = sat_st(41'(st_pri[i]) + 41'(corr));
    new_cv = sat_cv(53'(cv_pri[{i, j}]) - 53'(dcov));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (meas.func == FUNC_UPDATE && started) ? ST_MAC : ST_OUT;
        end
      end
      ST_MAC: begin
        if (part == 2'd3 && term) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (job == JOB_NUM && ok) state_next = ST_DIV;
        else if (job == JOB_CP && i == 2'd3 && j == 2'd3) state_next = ST_OUT;
        else state_next = ST_MAC;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_MAC;
      end
      ST_OUT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      lost_ticks <= '0;
      for (int s = 0; s < STATE_DIM; s++) begin
        st_pri[s]  <= '0;
        st_post[s] <= '0;
      end
      for (int e = 0; e < COV_N; e++) begin
        cv_pri[e]  <= '0;
        cv_post[e] <= '0;
      end
    end else begin
      if (accept) begin
        case (meas.func)
          FUNC_PREDICT: begin
            if (started) begin
              st_pri  <= pred_st;
              st_post <= pred_st;
              cv_pri  <= pred_cov;
              cv_post <= pred_cov;
              if (lost_ticks != '1) lost_ticks <= lost_ticks + 1'b1;
            end
          end
          FUNC_UPDATE, FUNC_INIT: begin
            if (meas.func == FUNC_UPDATE && started) begin
              lost_ticks <= '0;
            end else begin
              if (!started) begin
                for (int e = 0; e < COV_N; e++) begin
                  cv_post[e] <= (e % (STATE_DIM + 1) == 0) ?
                                CW'($signed({1'b0, initial_cov})) : '0;
                end
              end
              st_post[0] <= meas.meas_x;
              st_post[1] <= meas.meas_y;
              st_post[2] <= '0;
              st_post[3] <= '0;
              started    <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (state == ST_FIN && job == JOB_CS) st_post[i] <= new_st;
      if (state == ST_FIN && job == JOB_CP) cv_post[{i, j}] <= new_cv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job  <= JOB_DET;
      i    <= '0;
      j    <= '0;
      g    <= 1'b0;
      term <= 1'b0;
      part <= '0;
      ok   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            mx       <= meas.meas_x;
            my       <= meas.meas_y;
            zero_pos <= (meas.func == FUNC_PREDICT) && !started;
            job  <= JOB_DET;
            i    <= '0;
            j    <= '0;
            g    <= 1'b0;
            term <= 1'b0;
            part <= '0;
          end
        end
        ST_MAC: begin
          part <= part + 1'b1;
          if (part == 2'd3) term <= !term;
        end
        ST_FIN: begin
          case (job)
            JOB_DET: begin
              det <= acc;
              ok  <= !acc[ACCW-1] && (acc != '0);
              job <= JOB_NUM;
            end
            JOB_NUM: begin
              if (!ok) begin
                if (!g) k0[i] <= '0;
                else k1[i] <= '0;
                g <= !g;
                if (g) begin
                  i <= i + 1'b1;
                  if (i == 2'd3) job <= JOB_CS;
                end
              end
            end
            JOB_CS: begin
              job <= JOB_CP;
              j   <= '0;
            end
            JOB_CP: begin
              j <= j + 1'b1;
              if (j == 2'd3) begin
                job <= JOB_CS;
                i   <= i + 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          if (div_done) begin
            if (!g) k0[i] <= div_q;
            else k1[i] <= div_q;
            g <= !g;
            if (g) begin
              i <= i + 1'b1;
              if (i == 2'd3) job <= JOB_CS;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.pos_x     <= zero_pos ? '0 : st_post[0];
      res.pos_y     <= zero_pos ? '0 : st_post[1];
      res.tracking  <= started && (lost_ticks < lost_limit);
      res.ready_res <= started;
    end
  end

`ifndef SYNTH
  a_div_only_ok: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> ok)
    else $error("divider running with non-positive determinant");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !meas.ready)
    else $error("input taken while an item is in flight");

  a_track_needs_start: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready_res |-> !res.tracking)
    else $error("tracking reported before init");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !started && state == ST_IDLE)
    else $error("reset did not clear tracker");
`endif

endmodule

// ===== rtl/core/cvkt_mac.sv =====
// ----------------------------------------------------------------------------
// cvkt_mac
// Shared multiply-accumulate: one partial product of two signed operands per
// cycle while enabled, four partial products per full product.
// ----------------------------------------------------------------------------
module cvkt_mac (
  input  logic                             clk,
  input  cvkt_pkg::mac_ctl_t               ctl,
  input  logic signed [cvkt_pkg::OPW-1:0]  a,
  input  logic signed [cvkt_pkg::OPW-1:0]  b,
  output logic signed [cvkt_pkg::ACCW-1:0] acc
);
  import cvkt_pkg::*;

  logic [OPW-1:0]         a_mag;
  logic [OPW-1:0]         b_mag;
  logic [HIW-1:0]         a_h;
  logic [HIW-1:0]         b_h;
  logic [PPW-1:0]         pp;
  logic [ACCW-1:0]        pp_sh;
  logic                   neg;
  logic signed [ACCW-1:0] base;
  logic signed [ACCW-1:0] term;

  always_comb begin
    a_mag = a[OPW-1] ? $unsigned(-a) : $unsigned(a);
    b_mag = b[OPW-1] ? $unsigned(-b) : $unsigned(b);
    a_h   = ctl.part[0] ? a_mag[OPW-1:HALF] : HIW'(a_mag[HALF-1:0]);
    b_h   = ctl.part[1] ? b_mag[OPW-1:HALF] : HIW'(b_mag[HALF-1:0]);
    pp    = PPW'(a_h) * PPW'(b_h);
    case (ctl.part)
      2'b00:   pp_sh = ACCW'(pp);
      2'b11:   pp_sh = ACCW'(pp) << (2 * HALF);
      default: pp_sh = ACCW'(pp) << HALF;
    endcase
    neg  = a[OPW-1] ^ b[OPW-1] ^ ctl.sub;
    term = neg ? -$signed(pp_sh) : $signed(pp_sh);
    base = ctl.clr ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= base + term;
    end
  end

endmodule

// ===== rtl/core/cvkt_div.sv =====
// ----------------------------------------------------------------------------
// cvkt_div
// Restoring divider for the gain: min(floor(|n| * 2^32 / d), 2^47 - 1) with
// the sign of n, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cvkt_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [cvkt_pkg::ACCW-1:0] num,
  input  logic signed [cvkt_pkg::ACCW-1:0] den,
  output logic                             done,
  output logic signed [cvkt_pkg::KW-1:0]   q
);
  import cvkt_pkg::*;

  logic              busy;
  logic [POSW-1:0]   pos;
  logic [NMW-1:0]    n_mag;
  logic [REMW-1:0]   d;
  logic [REMW-1:0]   rem;
  logic [QW-1:0]     quo;
  logic              over;
  logic              neg;
  logic              nbit;
  logic [REMW-1:0]   trial;
  logic              ge;
  logic [POSW-1:0]   nidx;
  logic [KW-1:0]     mag;
  logic [ACCW-1:0]   num_abs;

  always_comb begin
    num_abs = num[ACCW-1] ? $unsigned(-num) : $unsigned(num);
    nidx    = pos - POSW'(FRAC);
    nbit    = (pos >= POSW'(FRAC)) ? n_mag[nidx[$clog2(NMW)-1:0]] : 1'b0;
    trial   = {rem[REMW-2:0], nbit};
    ge      = trial >= d;
    mag     = over ? KW'({QW{1'b1}}) : KW'(quo);
    q       = neg ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && pos == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_mag <= num_abs[NMW-1:0];
      d     <= den[REMW-1:0];
      neg   <= num[ACCW-1];
      rem   <= '0;
      quo   <= '0;
      over  <= 1'b0;
      pos   <= POSW'(DIV_TOP);
    end else if (busy) begin
      rem <= ge ? trial - d : trial;
      quo <= {quo[QW-2:0], ge};
      if (ge && pos >= POSW'(QW)) begin
        over <= 1'b1;
      end
      pos <= pos - 1'b1;
    end
  end

endmodule
